// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the I2C EEPROM byte master RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside of reset.
`define IEE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds at a rising clock edge outside of reset.
`define IEE_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/iee_pkg.sv =====
// Types, codes and constants of the I2C EEPROM byte master.
// No dependencies; used by the interfaces, the engine and the top level.
package iee_pkg;

    localparam int MEM_BYTES_DEFAULT = 2048;
    localparam logic [7:0] HALF_BIT_RESET = 8'd25;
    localparam logic [7:0] DEV_SELECT = 8'hA0;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_RAND_READ  = 2'd1;
    localparam logic [1:0] OP_BYTE_WRITE = 2'd2;
    localparam logic [1:0] OP_SEQ_READ   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_NACK    = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_S1A     = 5'd1,
        PH_S1B     = 5'd2,
        PH_S1C     = 5'd3,
        PH_DEVW_LO = 5'd4,
        PH_DEVW_HI = 5'd5,
        PH_ADDR_LO = 5'd6,
        PH_ADDR_HI = 5'd7,
        PH_DATA_LO = 5'd8,
        PH_DATA_HI = 5'd9,
        PH_S2A     = 5'd10,
        PH_S2B     = 5'd11,
        PH_S2C     = 5'd12,
        PH_DEVR_LO = 5'd13,
        PH_DEVR_HI = 5'd14,
        PH_RX_LO   = 5'd15,
        PH_RX_HI   = 5'd16,
        PH_PA      = 5'd17,
        PH_PB      = 5'd18,
        PH_PC      = 5'd19
    } phase_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [10:0] mem_address;
        logic [7:0]  write_byte;
        logic [11:0] read_count;
        logic        sda_sample;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       byte_valid;
        logic [7:0] byte_out;
        logic       last_byte;
        logic [1:0] status_code;
    } result_t;

endpackage

// ===== rtl/iee_in_if.sv =====
// Input channel of the I2C EEPROM byte master: valid/ready plus one item.
// Depends on iee_pkg.
interface iee_in_if;
    import iee_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [10:0] mem_address;
    logic [7:0]  write_byte;
    logic [11:0] read_count;
    logic        sda_sample;

    modport source (
        output valid, operation, mem_address, write_byte, read_count, sda_sample,
        input  ready
    );
    modport sink (
        input  valid, operation, mem_address, write_byte, read_count, sda_sample,
        output ready
    );
endinterface

// ===== rtl/iee_out_if.sv =====
// Result channel of the I2C EEPROM byte master: valid/ready plus one result.
// Depends on iee_pkg.
interface iee_out_if;
    import iee_pkg::*;

    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] byte_out;
    logic       last_byte;
    logic [1:0] status_code;

    modport source (
        output valid, scl_level, sda_level, busy_res, byte_valid, byte_out,
               last_byte, status_code,
        input  ready
    );
    modport sink (
        input  valid, scl_level, sda_level, busy_res, byte_valid, byte_out,
               last_byte, status_code,
        output ready
    );
endinterface

// ===== rtl/i2c_eeprom_byte_master.sv =====
// Top level of the I2C EEPROM byte master: handshakes, config register.
// Depends on iee_pkg, iee_in_if, iee_out_if, iee_engine, assert_macros.svh.
//
//   channel  | dir | moves per transfer
//   ---------+-----+-----------------------------------------------------
//   in_ch    | in  | operation, mem_address, write_byte, read_count, sda
//   out_ch   | out | scl/sda levels, busy, read byte, last marker, status
//   cfg_wr_* | in  | half_bit_ticks, written on cfg_wr_en (no handshake)
//
// One item per cycle sustained while out_ch.ready holds: an item waits in the input register,
// where the engine steps once on it and the result lands in the output register.
// Reset (rst_n, async low) leaves the bus idle and half_bit_ticks at 25.
// A stalled result holds the output register; the input register still takes
// one more item, then in_ch.ready drops until the result drains.
`include "assert_macros.svh"

module i2c_eeprom_byte_master #(
    parameter int MEM_BYTES = iee_pkg::MEM_BYTES_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    iee_in_if.sink     in_ch,
    iee_out_if.source  out_ch
);
    import iee_pkg::*;

    logic       half_bit_ticks_reg;
    logic [7:0] half_bits_reg;
    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    result_t    step_res;
    logic       fire;
    logic       in_xfer;

    // Step the engine when an item waits and the result slot is free or draining.
    assign fire    = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_xfer = in_ch.valid && in_ch.ready;

    assign in_ch.ready = !in_valid_reg || fire;

    // Hold the tick period; a write takes effect at the next step, even mid-transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_bits_reg      <= HALF_BIT_RESET;
            half_bit_ticks_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            half_bits_reg      <= cfg_wr_data;
            half_bit_ticks_reg <= 1'b1;
        end
    end

    // Input register: capture on transfer, drop once the engine steps on it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_item_reg.operation   <= in_ch.operation;
            in_item_reg.mem_address <= in_ch.mem_address;
            in_item_reg.write_byte  <= in_ch.write_byte;
            in_item_reg.read_count  <= in_ch.read_count;
            in_item_reg.sda_sample  <= in_ch.sda_sample;
        end
    end

    iee_engine #(
        .MEM_BYTES (MEM_BYTES)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (fire),
        .item           (in_item_reg),
        .half_bit_ticks (half_bits_reg),
        .res            (step_res)
    );

    // Output register: load on a step, clear when the sink takes the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_res_reg <= step_res;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.scl_level   = out_res_reg.scl_level;
    assign out_ch.sda_level   = out_res_reg.sda_level;
    assign out_ch.busy_res    = out_res_reg.busy_res;
    assign out_ch.byte_valid  = out_res_reg.byte_valid;
    assign out_ch.byte_out    = out_res_reg.byte_out;
    assign out_ch.last_byte   = out_res_reg.last_byte;
    assign out_ch.status_code = out_res_reg.status_code;

    `IEE_ASSERT(a_step_fills_output, clk, rst_n,
        fire |=> out_valid_reg,
        "engine step produced no result")
    `IEE_NEVER(a_no_result_overwrite, clk, rst_n,
        out_valid_reg && !out_ch.ready && fire,
        "pending result overwritten")
    `IEE_ASSERT(a_item_kept_until_step, clk, rst_n,
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_item_reg)),
        "waiting item lost before its step")
    `IEE_ASSERT(a_cfg_write_lands, clk, rst_n,
        cfg_wr_en |=> (half_bit_ticks_reg && half_bits_reg == $past(cfg_wr_data)),
        "config write not taken")
endmodule

// ===== rtl/iee_engine.sv =====
// Bus state machine of the I2C EEPROM byte master: one step per item.
// Depends on iee_pkg and assert_macros.svh.
`include "assert_macros.svh"

module iee_engine #(
    parameter int MEM_BYTES = iee_pkg::MEM_BYTES_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  iee_pkg::item_t   item,
    input  logic [7:0]       half_bit_ticks,
    output iee_pkg::result_t res
);
    import iee_pkg::*;

    localparam logic [11:0] MEM_LIMIT = 12'(MEM_BYTES);

    phase_t      phase_reg, phase_next;
    logic [7:0]  tick_count_reg, tick_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [10:0] saved_address_reg, saved_address_next;
    logic [7:0]  saved_data_reg, saved_data_next;
    logic [11:0] bytes_left_reg, bytes_left_next;
    logic [1:0]  op_kind_reg, op_kind_next;

    logic [1:0]  status;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        rx_last;

    logic [7:0]  half;
    logic [8:0]  tick_inc;
    logic [7:0]  block_sel;
    logic [11:0] span;
    logic [11:0] bytes_dec;
    logic        tx_bit;
    logic        rx_drive;
    logic        scl;
    logic        sda;

    assign half      = (half_bit_ticks == 8'd0) ? 8'd1 : half_bit_ticks;
    assign tick_inc  = {1'b0, tick_count_reg} + 9'd1;
    assign block_sel = DEV_SELECT | {4'd0, saved_address_reg[10:8], 1'b0};
    assign span      = MEM_LIMIT - {1'b0, item.mem_address};
    assign bytes_dec = (bytes_left_reg != 12'd0) ? bytes_left_reg - 12'd1 : 12'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            tick_count_reg    <= '0;
            shift_reg         <= '0;
            bit_index_reg     <= '0;
            saved_address_reg <= '0;
            saved_data_reg    <= '0;
            bytes_left_reg    <= '0;
            op_kind_reg       <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            tick_count_reg    <= tick_count_next;
            shift_reg         <= shift_next;
            bit_index_reg     <= bit_index_next;
            saved_address_reg <= saved_address_next;
            saved_data_reg    <= saved_data_next;
            bytes_left_reg    <= bytes_left_next;
            op_kind_reg       <= op_kind_next;
        end
    end

    // Next state: command decode from idle, else segment timing and advance.
    always_comb
    begin
        phase_next         = phase_reg;
        tick_count_next    = tick_count_reg;
        shift_next         = shift_reg;
        bit_index_next     = bit_index_reg;
        saved_address_next = saved_address_reg;
        saved_data_next    = saved_data_reg;
        bytes_left_next    = bytes_left_reg;
        op_kind_next       = op_kind_reg;
        status             = ST_OK;
        rx_valid           = 1'b0;
        rx_byte            = 8'd0;
        rx_last            = 1'b0;

        if (step)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (item.operation != OP_TICK)
                begin
                    if (({1'b0, item.mem_address} >= MEM_LIMIT) ||
                        ((item.operation == OP_SEQ_READ) &&
                         ((item.read_count == 12'd0) || (item.read_count > span))))
                    begin
                        status = ST_REFUSED;
                    end
                    else
                    begin
                        saved_address_next = item.mem_address;
                        saved_data_next    = item.write_byte;
                        op_kind_next       = item.operation;
                        case (item.operation)
                            OP_SEQ_READ:  bytes_left_next = item.read_count;
                            OP_RAND_READ: bytes_left_next = 12'd1;
                            default:      bytes_left_next = 12'd0;
                        endcase
                        shift_next      = 8'd0;
                        bit_index_next  = 4'd0;
                        tick_count_next = 8'd0;
                        phase_next      = PH_S1A;
                    end
                end
            end
            else if (tick_inc < {1'b0, half})
            begin
                tick_count_next = tick_inc[7:0];
            end
            else
            begin
                tick_count_next = 8'd0;
                case (phase_reg)
                    PH_S1A: phase_next = PH_S1B;
                    PH_S1B: phase_next = PH_S1C;
                    PH_S1C:
                    begin
                        phase_next     = PH_DEVW_LO;
                        shift_next     = block_sel;
                        bit_index_next = 4'd0;
                    end
                    PH_S2A: phase_next = PH_S2B;
                    PH_S2B: phase_next = PH_S2C;
                    PH_S2C:
                    begin
                        phase_next     = PH_DEVR_LO;
                        shift_next     = block_sel | 8'd1;
                        bit_index_next = 4'd0;
                    end
                    PH_DEVW_LO: phase_next = PH_DEVW_HI;
                    PH_ADDR_LO: phase_next = PH_ADDR_HI;
                    PH_DATA_LO: phase_next = PH_DATA_HI;
                    PH_DEVR_LO: phase_next = PH_DEVR_HI;
                    PH_RX_LO:   phase_next = PH_RX_HI;
                    PH_DEVW_HI, PH_ADDR_HI, PH_DATA_HI, PH_DEVR_HI:
                    begin
                        if (bit_index_reg < BITS_PER_BYTE)
                        begin
                            bit_index_next = bit_index_reg + 4'd1;
                            case (phase_reg)
                                PH_DEVW_HI: phase_next = PH_DEVW_LO;
                                PH_ADDR_HI: phase_next = PH_ADDR_LO;
                                PH_DATA_HI: phase_next = PH_DATA_LO;
                                default:    phase_next = PH_DEVR_LO;
                            endcase
                        end
                        else if (item.sda_sample)
                        begin
                            status     = ST_NACK;
                            phase_next = PH_PA;
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_DEVW_HI:
                                begin
                                    phase_next     = PH_ADDR_LO;
                                    shift_next     = saved_address_reg[7:0];
                                    bit_index_next = 4'd0;
                                end
                                PH_ADDR_HI:
                                begin
                                    if (op_kind_reg == OP_BYTE_WRITE)
                                    begin
                                        phase_next     = PH_DATA_LO;
                                        shift_next     = saved_data_reg;
                                        bit_index_next = 4'd0;
                                    end
                                    else
                                    begin
                                        phase_next = PH_S2A;
                                    end
                                end
                                PH_DATA_HI: phase_next = PH_PA;
                                default:
                                begin
                                    phase_next     = PH_RX_LO;
                                    shift_next     = 8'd0;
                                    bit_index_next = 4'd0;
                                end
                            endcase
                        end
                    end
                    PH_RX_HI:
                    begin
                        if (bit_index_reg < BITS_PER_BYTE)
                        begin
                            shift_next     = {shift_reg[6:0], item.sda_sample};
                            bit_index_next = bit_index_reg + 4'd1;
                            if (bit_index_next == BITS_PER_BYTE)
                            begin
                                rx_valid = 1'b1;
                                rx_byte  = shift_next;
                                rx_last  = (bytes_left_reg <= 12'd1);
                            end
                            phase_next = PH_RX_LO;
                        end
                        else
                        begin
                            bytes_left_next = bytes_dec;
                            if (bytes_dec == 12'd0)
                            begin
                                phase_next = PH_PA;
                            end
                            else
                            begin
                                phase_next     = PH_RX_LO;
                                shift_next     = 8'd0;
                                bit_index_next = 4'd0;
                            end
                        end
                    end
                    PH_PA: phase_next = PH_PB;
                    PH_PB: phase_next = PH_PC;
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // Outputs: pin levels follow the state after this step.
    always_comb
    begin
        tx_bit   = (bit_index_next < BITS_PER_BYTE) ?
                   shift_next[3'd7 - bit_index_next[2:0]] : 1'b1;
        rx_drive = (bit_index_next < BITS_PER_BYTE) ? 1'b1 :
                   ((bytes_left_next > 12'd1) ? 1'b0 : 1'b1);
        case (phase_next)
            PH_S1A, PH_S2A:
            begin
                scl = 1'b0;
                sda = 1'b1;
            end
            PH_S1B, PH_S2B:
            begin
                scl = 1'b1;
                sda = 1'b1;
            end
            PH_S1C, PH_S2C:
            begin
                scl = 1'b1;
                sda = 1'b0;
            end
            PH_DEVW_LO, PH_ADDR_LO, PH_DATA_LO, PH_DEVR_LO:
            begin
                scl = 1'b0;
                sda = tx_bit;
            end
            PH_DEVW_HI, PH_ADDR_HI, PH_DATA_HI, PH_DEVR_HI:
            begin
                scl = 1'b1;
                sda = tx_bit;
            end
            PH_RX_LO:
            begin
                scl = 1'b0;
                sda = rx_drive;
            end
            PH_RX_HI:
            begin
                scl = 1'b1;
                sda = rx_drive;
            end
            PH_PA:
            begin
                scl = 1'b0;
                sda = 1'b0;
            end
            PH_PB:
            begin
                scl = 1'b1;
                sda = 1'b0;
            end
            default:
            begin
                scl = 1'b1;
                sda = 1'b1;
            end
        endcase

        res.scl_level   = scl;
        res.sda_level   = sda;
        res.busy_res    = (phase_next != PH_IDLE);
        res.byte_valid  = rx_valid;
        res.byte_out    = rx_byte;
        res.last_byte   = rx_last;
        res.status_code = status;
    end

    `IEE_ASSERT(a_rx_only_in_rx_hi, clk, rst_n,
        rx_valid |-> (step && phase_reg == PH_RX_HI),
        "read byte reported outside a receive high half")
    `IEE_ASSERT(a_nack_goes_to_stop, clk, rst_n,
        (step && status == ST_NACK) |=> (phase_reg == PH_PA),
        "slave NACK did not lead to stop")
    `IEE_ASSERT(a_refused_stays_idle, clk, rst_n,
        (step && status == ST_REFUSED) |=> (phase_reg == PH_IDLE),
        "refused command left idle")
endmodule
